// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/rbap_pkg.sv =====
// ----------------------------------------------------------------------------
// rbap_pkg
// Types and constants shared by the bulk-string array parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbap_pkg;

  // Classification of one byte.
  typedef enum logic [2:0] {
    KIND_FRAMING  = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_ELEM_END = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_ERROR    = 3'd4,
    KIND_IGNORED  = 3'd5
  } kind_e;

  // Error codes reported with the error and ignored kinds.
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_STAR     = 4'd1,
    ERR_BAD_COUNT   = 4'd2,
    ERR_NO_DOLLAR   = 4'd3,
    ERR_BAD_LENGTH  = 4'd4,
    ERR_NO_LF       = 4'd5,
    ERR_NO_CRLF     = 4'd6,
    ERR_COUNT_OVER  = 4'd7,
    ERR_LENGTH_OVER = 4'd8,
    ERR_EMPTY_NUM   = 4'd9
  } err_e;

  // Configuration register indexes.
  localparam logic CFG_ELEMENT_LIMIT = 1'b0;
  localparam logic CFG_LENGTH_LIMIT  = 1'b1;

  // Register reset values.
  localparam logic [10:0] ELEMENT_LIMIT_RST = 11'd1024;
  localparam logic [15:0] LENGTH_LIMIT_RST  = 16'hFFFF;

  // Protocol characters.
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [9:0]  element_index;
    logic [10:0] array_count;
    err_e        error_code;
    logic [23:0] message_bytes;
  } result_t;

endpackage

// ===== design/rbap_parser.sv =====
// ----------------------------------------------------------------------------
// rbap_parser
// Parse state machine: classifies one byte per cycle and updates its state on each accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbap_parser #(
  parameter int MAX_ELEMENTS      = 1024,
  parameter int MAX_STRING_LENGTH = 65535,
  parameter int BYTE_COUNT_BITS   = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  output rbap_pkg::result_t      result_o
);

  typedef enum logic [3:0] {
    MODE_STAR     = 4'd0,
    MODE_COUNT    = 4'd1,
    MODE_COUNT_LF = 4'd2,
    MODE_DOLLAR   = 4'd3,
    MODE_LEN      = 4'd4,
    MODE_LEN_LF   = 4'd5,
    MODE_PAYLOAD  = 4'd6,
    MODE_STR_CR   = 4'd7,
    MODE_STR_LF   = 4'd8,
    MODE_ERROR    = 4'd9
  } mode_e;

  // Limits in force never exceed what the registers can hold.
  localparam int ElemCapInt = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
  localparam int LenCapInt  = (MAX_STRING_LENGTH > 65535) ? 65535 : MAX_STRING_LENGTH;
  localparam logic [16:0] ElemCap = 17'(ElemCapInt);
  localparam logic [16:0] LenCap  = 17'(LenCapInt);
  localparam logic [BYTE_COUNT_BITS-1:0] CntMax = {BYTE_COUNT_BITS{1'b1}};

  logic [10:0]                elem_limit_q;
  logic [15:0]                len_limit_q;
  mode_e                      mode_q, mode_d;
  logic [15:0]                acc_q, acc_d;
  logic                       seen_q, seen_d;
  logic [10:0]                size_q, size_d;
  logic [10:0]                cur_q, cur_d;
  logic [15:0]                left_q, left_d;
  logic [BYTE_COUNT_BITS-1:0] cnt_q, cnt_d;
  rbap_pkg::err_e             err_q, err_d;

  logic [16:0]                elem_cap;
  logic [16:0]                len_cap;
  logic [16:0]                num_limit;
  logic                       is_digit;
  logic [19:0]                num_next;
  logic                       num_over;
  logic [BYTE_COUNT_BITS-1:0] cnt_inc;
  logic [11:0]                cur_plus;
  rbap_pkg::kind_e            kind;
  rbap_pkg::err_e             err;
  logic [7:0]                 pay;
  logic [BYTE_COUNT_BITS-1:0] msg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_limit_q <= rbap_pkg::ELEMENT_LIMIT_RST;
      len_limit_q  <= rbap_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rbap_pkg::CFG_ELEMENT_LIMIT) begin
        elem_limit_q <= cfg_data_i[10:0];
      end else begin
        len_limit_q <= cfg_data_i;
      end
    end
  end

  // Effective limits and the shared decimal digit step.
  assign elem_cap  = ({6'd0, elem_limit_q} < ElemCap) ? {6'd0, elem_limit_q} : ElemCap;
  assign len_cap   = ({1'b0, len_limit_q} < LenCap) ? {1'b0, len_limit_q} : LenCap;
  assign num_limit = (mode_q == MODE_LEN) ? len_cap : elem_cap;
  assign is_digit  = (data_byte_i >= rbap_pkg::CHAR_ZERO) &&
                     (data_byte_i <= rbap_pkg::CHAR_NINE);
  assign num_next  = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(data_byte_i[3:0]);
  assign num_over  = num_next > {3'd0, num_limit};
  assign cnt_inc   = (cnt_q == CntMax) ? cnt_q : cnt_q + BYTE_COUNT_BITS'(1);
  assign cur_plus  = {1'b0, cur_q} + 12'd1;

  // Next state and result for the byte on the input.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    size_d = size_q;
    cur_d  = cur_q;
    left_d = left_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    kind   = rbap_pkg::KIND_FRAMING;
    err    = rbap_pkg::ERR_NONE;
    pay    = 8'd0;
    msg    = '0;
    result_o.element_index = cur_q[9:0];

    if (mode_q == MODE_ERROR) begin
      kind = rbap_pkg::KIND_IGNORED;
      err  = err_q;
    end else begin
      cnt_d = cnt_inc;
      case (mode_q)
        MODE_STAR: begin
          if (data_byte_i == rbap_pkg::CHAR_STAR) begin
            cnt_d  = BYTE_COUNT_BITS'(1);
            size_d = 11'd0;
            cur_d  = 11'd0;
            result_o.element_index = 10'd0;
            acc_d  = 16'd0;
            seen_d = 1'b0;
            mode_d = MODE_COUNT;
          end else begin
            err = rbap_pkg::ERR_NO_STAR;
          end
        end
        MODE_COUNT, MODE_LEN: begin
          if (is_digit) begin
            if (num_over) begin
              err = (mode_q == MODE_COUNT) ? rbap_pkg::ERR_COUNT_OVER
                                           : rbap_pkg::ERR_LENGTH_OVER;
            end else begin
              acc_d  = num_next[15:0];
              seen_d = 1'b1;
            end
          end else if (data_byte_i == rbap_pkg::CHAR_CR) begin
            if (!seen_q) begin
              err = rbap_pkg::ERR_EMPTY_NUM;
            end else if (mode_q == MODE_COUNT) begin
              size_d = acc_q[10:0];
              mode_d = MODE_COUNT_LF;
            end else begin
              left_d = acc_q;
              mode_d = MODE_LEN_LF;
            end
          end else begin
            err = (mode_q == MODE_COUNT) ? rbap_pkg::ERR_BAD_COUNT
                                         : rbap_pkg::ERR_BAD_LENGTH;
          end
        end
        MODE_COUNT_LF: begin
          if (data_byte_i != rbap_pkg::CHAR_LF) begin
            err = rbap_pkg::ERR_NO_LF;
          end else if (size_q == 11'd0) begin
            kind   = rbap_pkg::KIND_COMPLETE;
            msg    = cnt_inc;
            mode_d = MODE_STAR;
          end else begin
            cur_d  = 11'd0;
            mode_d = MODE_DOLLAR;
          end
        end
        MODE_DOLLAR: begin
          if (data_byte_i == rbap_pkg::CHAR_DOLLAR) begin
            acc_d  = 16'd0;
            seen_d = 1'b0;
            mode_d = MODE_LEN;
          end else begin
            err = rbap_pkg::ERR_NO_DOLLAR;
          end
        end
        MODE_LEN_LF: begin
          if (data_byte_i == rbap_pkg::CHAR_LF) begin
            mode_d = (left_q != 16'd0) ? MODE_PAYLOAD : MODE_STR_CR;
          end else begin
            err = rbap_pkg::ERR_NO_LF;
          end
        end
        MODE_PAYLOAD: begin
          kind   = rbap_pkg::KIND_PAYLOAD;
          pay    = data_byte_i;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            mode_d = MODE_STR_CR;
          end
        end
        MODE_STR_CR: begin
          if (data_byte_i == rbap_pkg::CHAR_CR) begin
            mode_d = MODE_STR_LF;
          end else begin
            err = rbap_pkg::ERR_NO_CRLF;
          end
        end
        MODE_STR_LF: begin
          if (data_byte_i != rbap_pkg::CHAR_LF) begin
            err = rbap_pkg::ERR_NO_CRLF;
          end else if (cur_plus >= {1'b0, size_q}) begin
            kind   = rbap_pkg::KIND_COMPLETE;
            msg    = cnt_inc;
            cur_d  = 11'd0;
            mode_d = MODE_STAR;
          end else begin
            kind   = rbap_pkg::KIND_ELEM_END;
            cur_d  = cur_plus[10:0];
            mode_d = MODE_DOLLAR;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase

      // The first error latches and parks the parser.
      if (err != rbap_pkg::ERR_NONE) begin
        kind   = rbap_pkg::KIND_ERROR;
        err_d  = err;
        mode_d = MODE_ERROR;
      end
    end

    result_o.kind          = kind;
    result_o.payload_byte  = pay;
    result_o.array_count   = size_d;
    result_o.error_code    = err;
    result_o.message_bytes = 24'(msg);
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STAR;
      acc_q  <= 16'd0;
      seen_q <= 1'b0;
      size_q <= 11'd0;
      cur_q  <= 11'd0;
      left_q <= 16'd0;
      cnt_q  <= '0;
      err_q  <= rbap_pkg::ERR_NONE;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
      size_q <= size_d;
      cur_q  <= cur_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== design/rbap_out_reg.sv =====
// ----------------------------------------------------------------------------
// rbap_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbap_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rbap_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              valid_o,
  output logic              space_o,
  output rbap_pkg::result_t result_o
);

  logic              valid_q;
  rbap_pkg::result_t data_q;

  // A new result may be loaded when the register is empty or the held one leaves in the same cycle.
  assign space_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== design/resp_bulk_array_parser_top.sv =====
// An accepted byte's result is registered; it shows on the master side in the next cycle.
// Throughput: one byte per cycle while the result register has space; the parse step is one
// state update plus a times-ten add. A stalled result register holds the next byte off; the
// ready path is one gate deep. Reset clears the parse state, the error latch and the byte
// counter at once and restores both limits to their reset values; a held result is dropped.
// ----------------------------------------------------------------------------
// resp_bulk_array_parser_top
// Streaming parser for an array of bulk strings, classifying one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module resp_bulk_array_parser_top #(
  parameter int MAX_ELEMENTS      = 1024,
  parameter int MAX_STRING_LENGTH = 65535,
  parameter int BYTE_COUNT_BITS   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] element_index,
                                      // [28:18] array_count, [32:29] error_code,
                                      // [56:33] message_bytes, [63:57] zero
  output logic [2:0]  m_axis_tuser    // [2:0] kind
);

  logic              accept;
  rbap_pkg::result_t step_result;
  rbap_pkg::result_t out_result;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Parse state machine.
  rbap_parser #(
    .MAX_ELEMENTS      (MAX_ELEMENTS),
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
    .BYTE_COUNT_BITS   (BYTE_COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .result_o    (step_result)
  );

  // Result register.
  rbap_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (step_result),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .space_o  (s_axis_tready),
    .result_o (out_result)
  );

  // Pack the result fields onto the master side.
  assign m_axis_tuser = out_result.kind;
  assign m_axis_tdata = {7'd0,
                         out_result.message_bytes,
                         out_result.error_code,
                         out_result.array_count,
                         out_result.element_index,
                         out_result.payload_byte};

  // A payload byte is only reported on payload results.
  `ASSERT_CLK(a_payload_only, (m_axis_tvalid && (m_axis_tuser != rbap_pkg::KIND_PAYLOAD)) |-> (m_axis_tdata[7:0] == 8'd0), "payload byte set on a non-payload result")

  // A byte count is only reported on completion.
  `ASSERT_CLK(a_count_on_complete, (m_axis_tvalid && (m_axis_tuser != rbap_pkg::KIND_COMPLETE)) |-> (m_axis_tdata[56:33] == 24'd0), "message byte count set without completion")

  // Error and ignored results always carry a code, and no other result does.
  `ASSERT_CLK(a_error_code, m_axis_tvalid |-> (((m_axis_tuser == rbap_pkg::KIND_ERROR) || (m_axis_tuser == rbap_pkg::KIND_IGNORED)) == (m_axis_tdata[32:29] != 4'd0)), "error code does not match result kind")

  // Once an error result is accepted, every later result is ignored.
  `ASSERT_CLK(a_error_sticky, (m_axis_tvalid && m_axis_tready && ((m_axis_tuser == rbap_pkg::KIND_ERROR) || (m_axis_tuser == rbap_pkg::KIND_IGNORED))) |=> (!m_axis_tvalid || (m_axis_tuser == rbap_pkg::KIND_IGNORED)), "result after an error was not ignored")

endmodule
